FILE: rtl/core/sorted_polynomial_term_accumulator_defines.svh
// assertion macros for the sorted polynomial term accumulator
`ifndef SORTED_POLYNOMIAL_TERM_ACCUMULATOR_DEFINES_SVH
`define SORTED_POLYNOMIAL_TERM_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define SPTA_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spta check failed");
`define SPTA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spta check failed");
`else
`define SPTA_ASSERT_SAME(label, ante, cons)
`define SPTA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/core/spta_pkg.sv
// shared types and constants of the sorted polynomial term accumulator
package spta_pkg;

	localparam int MAX_TERMS   = 64;
	// exponent bits kept in the table, at most the exponent field width
	localparam int EXP_BITS    = 8;
	localparam int EXP_FIELD_W = 8;
	localparam int COEF_W      = 32;
	localparam int ADDR_W      = $clog2(MAX_TERMS);
	localparam int CNT_W       = $clog2(MAX_TERMS + 1);

	localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_DUMP  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ADDED  = 3'd0,
		ST_MERGED = 3'd1,
		ST_FULL   = 3'd2,
		ST_TERM   = 3'd3,
		ST_EMPTY  = 3'd4
	} status_t;

	typedef struct packed {
		cmd_t                     command;
		logic signed [COEF_W-1:0] coefficient;
		logic [EXP_FIELD_W-1:0]   exponent;
	} item_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coefficient_out;
		logic [EXP_FIELD_W-1:0]   exponent_out;
		status_t                  status;
		logic                     last;
	} result_t;

	// one table entry
	typedef struct packed {
		logic signed [COEF_W-1:0] coef;
		logic [EXP_BITS-1:0]      expo;
	} term_t;

	// request from the sequencer to the term memory
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		term_t             wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

FILE: rtl/core/sorted_polynomial_term_accumulator.sv
// Sorted polynomial term accumulator. Terms sit in one table memory, sorted
// by descending exponent. A word is taken when start is high and busy is low.
// An add scans the table one entry per cycle from the highest exponent:
// it merges into a term of equal exponent, or inserts at the first place
// with a lower exponent by moving the tail up one entry at a time from the
// end and then writing the new term, or appends after the last term; on a
// full table an add that does not merge is dropped. An add into an empty
// table finishes in the accept cycle. A dump gives one term per cycle. The
// single read port of the table memory sets this pace. Each result word is
// shown for exactly one cycle with result_valid, the cycle after the work
// that makes it; the receiver cannot stall, and the next word may be taken
// in that cycle.
`include "sorted_polynomial_term_accumulator_defines.svh"

module sorted_polynomial_term_accumulator import spta_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output logic    result_valid,
	output result_t result
);

	ram_req_t         ram_req;
	term_t            rdata;
	logic [CNT_W-1:0] count;

	spta_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.rdata        (rdata),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result),
		.ram_req      (ram_req),
		.count        (count)
	);

	spta_term_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rdata)
	);

	`SPTA_ASSERT_SAME(a_count_range, 1'b1, count <= CNT_W'(MAX_TERMS))
	`SPTA_ASSERT_SAME(a_single_last, result_valid && result.status != ST_TERM, result.last)
	`SPTA_ASSERT_NEXT(a_clear_silent, start && !busy && item.command == CMD_CLEAR, !result_valid && count == '0)
	`SPTA_ASSERT_NEXT(a_add_progress, start && !busy && item.command == CMD_ADD, busy || result_valid)

endmodule

FILE: rtl/core/spta_sat_add.sv
// saturating q16.16 coefficient adder
module spta_sat_add import spta_pkg::*; (
	input  logic signed [COEF_W-1:0] a,
	input  logic signed [COEF_W-1:0] b,
	output logic signed [COEF_W-1:0] sum
);

	logic signed [COEF_W:0] wide;

	assign wide = {a[COEF_W-1], a} + {b[COEF_W-1], b};

	always_comb begin
		if (wide[COEF_W] != wide[COEF_W-1]) begin
			sum = wide[COEF_W] ? COEF_MIN : COEF_MAX;
		end else begin
			sum = wide[COEF_W-1:0];
		end
	end

endmodule

FILE: rtl/core/spta_term_ram.sv
// term table memory, one write and one registered read port
module spta_term_ram import spta_pkg::*; (
	input  logic     clk,
	input  ram_req_t req,
	output term_t    rdata
);

	term_t mem [MAX_TERMS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[req.raddr];
	end

endmodule

FILE: rtl/core/spta_ctrl.sv
// sequencer: scan, merge, shift-insert and dump over the term memory
module spta_ctrl import spta_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  item_t          item,
	input  term_t          rdata,
	output logic           busy,
	output logic           result_valid,
	output result_t        result,
	output ram_req_t       ram_req,
	output logic [CNT_W-1:0] count
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_PLACE,
		S_DUMP
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] pos_q;
	term_t             new_q;
	logic              valid_q;
	result_t           res_q;

	logic signed [COEF_W-1:0] merged;
	logic                     idx_last;
	logic                     full;
	logic [ADDR_W-1:0]        cnt_top;
	logic [EXP_BITS-1:0]      in_exp;

	spta_sat_add u_sat (
		.a   (rdata.coef),
		.b   (new_q.coef),
		.sum (merged)
	);

	assign in_exp   = item.exponent[EXP_BITS-1:0];
	assign idx_last = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;
	assign full     = cnt_q == CNT_W'(MAX_TERMS);
	assign cnt_top  = ADDR_W'(cnt_q - CNT_W'(1));

	// memory accesses; each state touches distinct entries, so no forwarding
	always_comb begin
		ram_req       = '0;
		ram_req.wdata = new_q;
		unique case (state_q)
			S_IDLE: begin
				if (start && item.command == CMD_ADD && cnt_q == '0) begin
					ram_req.we    = 1'b1;
					ram_req.wdata = '{coef: item.coefficient, expo: in_exp};
				end
			end
			S_SCAN: begin
				if (rdata.expo == new_q.expo) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = idx_q;
					ram_req.wdata = '{coef: merged, expo: new_q.expo};
				end else if (rdata.expo > new_q.expo) begin
					if (idx_last) begin
						ram_req.we    = !full;
						ram_req.waddr = ADDR_W'(cnt_q);
					end else begin
						ram_req.raddr = idx_q + ADDR_W'(1);
					end
				end else begin
					ram_req.raddr = cnt_top;
				end
			end
			S_SHIFT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = idx_q + ADDR_W'(1);
				ram_req.wdata = rdata;
				ram_req.raddr = idx_q - ADDR_W'(1);
			end
			S_PLACE: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = pos_q;
			end
			S_DUMP: begin
				ram_req.raddr = idx_q + ADDR_W'(1);
			end
			default: begin
				ram_req.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			pos_q   <= '0;
			new_q   <= '0;
			valid_q <= 1'b0;
			res_q   <= '0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						unique case (item.command)
							CMD_ADD: begin
								new_q <= '{coef: item.coefficient, expo: in_exp};
								idx_q <= '0;
								if (cnt_q == '0) begin
									cnt_q   <= CNT_W'(1);
									valid_q <= 1'b1;
									res_q   <= '{'0, '0, ST_ADDED, 1'b1};
								end else begin
									state_q <= S_SCAN;
								end
							end
							CMD_DUMP: begin
								idx_q <= '0;
								if (cnt_q == '0) begin
									valid_q <= 1'b1;
									res_q   <= '{'0, '0, ST_EMPTY, 1'b1};
								end else begin
									state_q <= S_DUMP;
								end
							end
							CMD_CLEAR: begin
								cnt_q <= '0;
							end
							CMD_NOP: begin
								cnt_q <= cnt_q;
							end
							default: begin
								cnt_q <= cnt_q;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (rdata.expo == new_q.expo) begin
						valid_q <= 1'b1;
						res_q   <= '{'0, '0, ST_MERGED, 1'b1};
						state_q <= S_IDLE;
					end else if (rdata.expo > new_q.expo) begin
						if (idx_last) begin
							valid_q <= 1'b1;
							state_q <= S_IDLE;
							if (full) begin
								res_q <= '{'0, '0, ST_FULL, 1'b1};
							end else begin
								cnt_q <= cnt_q + CNT_W'(1);
								res_q <= '{'0, '0, ST_ADDED, 1'b1};
							end
						end else begin
							idx_q <= idx_q + ADDR_W'(1);
						end
					end else if (full) begin
						valid_q <= 1'b1;
						res_q   <= '{'0, '0, ST_FULL, 1'b1};
						state_q <= S_IDLE;
					end else begin
						// open a hole at idx_q, moving the tail up from the end
						pos_q   <= idx_q;
						idx_q   <= cnt_top;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (idx_q == pos_q) begin
						state_q <= S_PLACE;
					end else begin
						idx_q <= idx_q - ADDR_W'(1);
					end
				end
				S_PLACE: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					valid_q <= 1'b1;
					res_q   <= '{'0, '0, ST_ADDED, 1'b1};
					state_q <= S_IDLE;
				end
				S_DUMP: begin
					valid_q <= 1'b1;
					res_q   <= '{rdata.coef, EXP_FIELD_W'(rdata.expo), ST_TERM, idx_last};
					if (idx_last) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + ADDR_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = state_q != S_IDLE;
	assign result_valid = valid_q;
	assign result       = res_q;
	assign count        = cnt_q;

endmodule

FILE: tb/sv/spta_term_checker.sv
// checker for the sorted polynomial term accumulator: own term table, expected words, compare
`timescale 1ns / 100ps

module spta_term_checker import spta_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   item,
	input  logic    result_valid,
	input  result_t result,
	output int      fails,
	output int      pending
);

	localparam int SHOWN_MAX = 30;

	logic signed [COEF_W-1:0] poly_coefs [MAX_TERMS];
	logic [EXP_BITS-1:0]      poly_expos [MAX_TERMS];
	int                       poly_len;
	result_t                  due_results [$];

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		if (fails < SHOWN_MAX)
			$display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want);
		fails++;
	endtask

	function automatic logic signed [COEF_W-1:0] sat_sum(
		input logic signed [COEF_W-1:0] a,
		input logic signed [COEF_W-1:0] b
	);
		logic signed [COEF_W:0] s;
		s = $signed({a[COEF_W-1], a}) + $signed({b[COEF_W-1], b});
		// top two bits differ only on overflow
		if (s[COEF_W] != s[COEF_W-1])
			return s[COEF_W] ? COEF_MIN : COEF_MAX;
		return s[COEF_W-1:0];
	endfunction

	// update the term table for one accepted word and queue the words it must give
	task automatic model_polynomial_word(input item_t w);
		result_t             r;
		logic [EXP_BITS-1:0] e;
		int                  p;
		r = '0;
		r.last = 1'b1;
		e = w.exponent[EXP_BITS-1:0];
		case (w.command)
			CMD_ADD: begin
				p = 0;
				while (p < poly_len && poly_expos[p] > e)
					p++;
				if (p < poly_len && poly_expos[p] == e) begin
					poly_coefs[p] = sat_sum(poly_coefs[p], w.coefficient);
					r.status = ST_MERGED;
				end else if (poly_len >= MAX_TERMS) begin
					r.status = ST_FULL;
				end else begin
					for (int k = poly_len; k > p; k--) begin
						poly_coefs[k] = poly_coefs[k-1];
						poly_expos[k] = poly_expos[k-1];
					end
					poly_coefs[p] = w.coefficient;
					poly_expos[p] = e;
					poly_len++;
					r.status = ST_ADDED;
				end
				due_results.push_back(r);
			end
			CMD_DUMP: begin
				if (poly_len == 0) begin
					r.status = ST_EMPTY;
					due_results.push_back(r);
				end else begin
					for (int k = 0; k < poly_len; k++) begin
						r = '0;
						r.coefficient_out = poly_coefs[k];
						r.exponent_out[EXP_BITS-1:0] = poly_expos[k];
						r.status = ST_TERM;
						r.last = (k == poly_len - 1);
						due_results.push_back(r);
					end
				end
			end
			CMD_CLEAR: poly_len = 0;
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			poly_len = 0;
			due_results.delete();
		end else begin
			// words of earlier items come out before anything accepted at this edge
			if (result_valid) begin
				if (due_results.size() == 0) begin
					report("unexpected word", 64'(result), '0);
				end else begin
					want = due_results.pop_front();
					if (result.coefficient_out !== want.coefficient_out)
						report("coefficient_out", 64'(result.coefficient_out),
							64'(want.coefficient_out));
					if (result.exponent_out !== want.exponent_out)
						report("exponent_out", 64'(result.exponent_out),
							64'(want.exponent_out));
					if (result.status !== want.status)
						report("status", 64'(result.status), 64'(want.status));
					if (result.last !== want.last)
						report("last", 64'(result.last), 64'(want.last));
				end
			end
			if (start && !busy)
				model_polynomial_word(item);
		end
		pending = due_results.size();
	end

endmodule

FILE: tb/sv/tb_top.sv
// stimulus and verdict for the sorted polynomial term accumulator
`timescale 1ns / 100ps

module tb_top import spta_pkg::*; ();

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 200;

	logic    clk;
	logic    arst_n;
	logic    start;
	item_t   item;
	logic    busy;
	logic    result_valid;
	result_t result;
	int      fails;
	int      pending;
	int      cycles;
	int      words_sent;
	int      gap_pct;

	sorted_polynomial_term_accumulator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result)
	);

	spta_term_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.fails        (fails),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic signed [COEF_W-1:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2, 3: return 32'($urandom_range(0, 262143)) - 32'd131072;
			default: return $urandom;
		endcase
	endfunction

	// called at a rising edge; returns at the edge where the word is taken
	task automatic send_word(input cmd_t c, input logic [COEF_W-1:0] coef,
		input logic [EXP_FIELD_W-1:0] e);
		logic taken;
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= '{command: c, coefficient: coef, exponent: e};
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		if (c != CMD_NOP)
			words_sent++;
	endtask

	// hold off until every expected word has come out
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
		@(posedge clk);
	endtask

	// fill all places, push past the top, merge into stored terms and dump everything
	task automatic fill_table();
		int base;
		base = $urandom_range(0, 3);
		send_word(CMD_CLEAR, rand_coef(), EXP_FIELD_W'($urandom_range(0, 255)));
		for (int i = 0; i < MAX_TERMS; i++)
			send_word(CMD_ADD, rand_coef(),
				EXP_FIELD_W'(base + 4 * ((i * 37) % MAX_TERMS)));
		for (int i = 0; i < 3; i++)
			send_word(CMD_ADD, rand_coef(),
				EXP_FIELD_W'(base + 1 + 4 * $urandom_range(0, 62)));
		for (int i = 0; i < 2; i++)
			send_word(CMD_ADD, rand_coef(),
				EXP_FIELD_W'(base + 4 * $urandom_range(0, 63)));
		send_word(CMD_DUMP, rand_coef(), EXP_FIELD_W'($urandom_range(0, 255)));
	endtask

	task automatic build_run();
		int kind;
		int n;
		bit narrow;
		kind = $urandom_range(0, 9);
		if (kind <= 6) begin
			if ($urandom_range(0, 2) == 0)
				send_word(CMD_CLEAR, rand_coef(), EXP_FIELD_W'($urandom_range(0, 255)));
			n = $urandom_range(1, 20);
			narrow = 1'($urandom_range(0, 1));
			// a narrow exponent pool makes merges and saturation common
			for (int i = 0; i < n; i++)
				send_word(CMD_ADD, rand_coef(),
					EXP_FIELD_W'(narrow ? $urandom_range(0, 15) : $urandom_range(0, 255)));
			send_word(CMD_DUMP, rand_coef(), EXP_FIELD_W'($urandom_range(0, 255)));
		end else if (kind == 7) begin
			send_word(CMD_DUMP, rand_coef(), EXP_FIELD_W'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(1, 5);
			for (int i = 0; i < n; i++)
				send_word(cmd_t'($urandom_range(0, 3)), $urandom,
					EXP_FIELD_W'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		words_sent = 0;
		gap_pct    = 0;
		arst_n <= 1'b0;
		start  <= 1'b0;
		item   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_word(CMD_DUMP, '0, 8'd0);
		send_word(CMD_NOP, 32'hFFFF_FFFF, 8'hFF);
		send_word(CMD_CLEAR, '0, 8'd0);
		send_word(CMD_ADD, COEF_MAX, 8'd0);
		send_word(CMD_ADD, COEF_MIN, 8'd255);
		send_word(CMD_ADD, 32'h0001_0000, 8'd128);
		send_word(CMD_ADD, 32'd1, 8'd0);
		send_word(CMD_ADD, 32'hFFFF_FFFF, 8'd255);
		// merge to zero keeps the term
		send_word(CMD_ADD, 32'hFFFF_0000, 8'd128);
		send_word(CMD_ADD, 32'h5555_5555, 8'd64);
		send_word(CMD_ADD, 32'hAAAA_AAAA, 8'd127);
		send_word(CMD_DUMP, '0, 8'd0);
		send_word(CMD_ADD, COEF_MIN, 8'd0);
		send_word(CMD_CLEAR, '0, 8'd0);
		send_word(CMD_DUMP, '0, 8'd0);
		send_word(CMD_ADD, $urandom, 8'd200);
		send_word(CMD_DUMP, '0, 8'd0);
		drain();

		gap_pct = 31;
		fill_table();
		while (words_sent < 170)
			build_run();
		drain();

		gap_pct = 86;
		fill_table();
		while (words_sent < 320)
			build_run();
		drain();

		gap_pct = 0;
		fill_table();
		while (words_sent < 470)
			build_run();

		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
